// File: hdl/sia_pkg.sv
`default_nettype none
package sia_pkg;

	localparam int ID_W         = 11;
	localparam int FUNC_W       = 2;
	localparam int STATUS_W     = 2;
	localparam int RECLAIM_W    = 16;
	localparam int CNT_W        = 16;
	localparam int ROW_W        = 32;
	localparam int ROW_LG       = 5;
	localparam int DEF_CAPACITY = 1024;
	localparam int APB_DW       = 32;
	localparam int APB_AW       = 3;

	localparam logic [RECLAIM_W-1:0] RECLAIM_RST = 16'd64;
	localparam logic [0:0]           REG_RECLAIM = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_REMOVE = 2'd1,
		FUNC_HAS    = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_ID_ZERO = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_CHECK = 2'd1,
		S_RESP  = 2'd2
	} state_t;

	typedef struct packed {
		logic accept;
		logic check;
	} cmd_t;

	typedef struct packed {
		logic quick;
		logic more;
	} sts_t;

endpackage
`default_nettype wire

// File: hdl/slot_id_allocator.sv
`default_nettype none
// Clear, ID zero and out-of-range IDs: done pulses the cycle after start is taken.
// Add, remove and has: S_CHECK reads a row of the occupancy RAM, then done pulses in
// S_RESP; an add stays in S_CHECK for each further 32-slot row that it scans (one row
// read per cycle). busy stays high through done; the next start is taken in the cycle
// after done. Reset clears the slot count, cursor and add counter, not the map RAM:
// slots at or past the count read as free. done is a one-cycle pulse, never stalled.
module slot_id_allocator #(
	parameter int CAPACITY = sia_pkg::DEF_CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [sia_pkg::FUNC_W-1:0]        func,
	input  wire logic [sia_pkg::ID_W-1:0]          entity_id,
	output logic                                   done,
	output logic      [sia_pkg::ID_W-1:0]          new_id,
	output logic                                   ok,
	output logic                                   slot_valid,
	output logic      [sia_pkg::STATUS_W-1:0]      status,
	output logic      [sia_pkg::ID_W-1:0]          slot_count,
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [sia_pkg::APB_AW-1:0]        paddr,
	input  wire logic [sia_pkg::APB_DW-1:0]        pwdata,
	output logic      [sia_pkg::APB_DW-1:0]        prdata,
	output logic                                   pready
);
	import sia_pkg::*;

	logic [RECLAIM_W-1:0] reclaim_q;
	logic                 reg_sel;
	cmd_t                 cmd;
	sts_t                 sts;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[APB_AW-1:2] == REG_RECLAIM);
	assign prdata  = reg_sel ? APB_DW'(reclaim_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reclaim_q <= RECLAIM_RST;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			reclaim_q <= pwdata[RECLAIM_W-1:0];
		end
	end

	sia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	sia_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.entity_id     (entity_id),
		.reclaim_after (reclaim_q),
		.new_id        (new_id),
		.ok            (ok),
		.slot_valid    (slot_valid),
		.status        (status),
		.slot_count    (slot_count)
	);

endmodule
`default_nettype wire

// File: hdl/sia_ram.sv
`default_nettype none
module sia_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// File: hdl/sia_ctrl.sv
`default_nettype none
module sia_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire sia_pkg::sts_t sts,
	output sia_pkg::cmd_t      cmd,
	output logic               busy,
	output logic               done
);
	import sia_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = sts.quick ? S_RESP : S_CHECK;
				end
			end
			S_CHECK: begin
				// for an add, keep scanning rows until a slot is taken or the table is full
				state_d = sts.more ? S_CHECK : S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.accept = 1'b0;
		cmd.check  = 1'b0;
		busy       = 1'b1;
		done       = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
			end
			S_RESP: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/sia_dp.sv
`default_nettype none
module sia_dp #(
	parameter int CAPACITY = sia_pkg::DEF_CAPACITY
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire sia_pkg::cmd_t                     cmd,
	output sia_pkg::sts_t                          sts,
	input  wire logic [sia_pkg::FUNC_W-1:0]        func,
	input  wire logic [sia_pkg::ID_W-1:0]          entity_id,
	input  wire logic [sia_pkg::RECLAIM_W-1:0]     reclaim_after,
	output logic      [sia_pkg::ID_W-1:0]          new_id,
	output logic                                   ok,
	output logic                                   slot_valid,
	output logic      [sia_pkg::STATUS_W-1:0]      status,
	output logic      [sia_pkg::ID_W-1:0]          slot_count
);
	import sia_pkg::*;

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int EW   = $clog2(CAPACITY + ROW_W + 1);
	localparam int CMPW = (CW > ID_W) ? CW : ID_W;
	localparam int ROWS = (CAPACITY + ROW_W - 1) / ROW_W;
	localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam logic [EW-1:0] CAP_E = EW'(CAPACITY);

	// state
	logic [CW-1:0]    cursor_q;
	logic [CW-1:0]    hw_q;
	logic [CNT_W-1:0] acnt_q;

	// per-transaction registers
	func_t            func_q;
	logic [ID_W-1:0]  id_q;
	logic [EW-1:0]    scan_q;
	logic [ID_W-1:0]  new_id_q;
	logic             ok_q;
	status_t          status_q;

	logic [CMPW-1:0]  id_e;
	logic [CMPW-1:0]  id_m1;
	logic [CMPW-1:0]  idq_m1;
	logic             id_zero;
	logic             id_in;
	logic             reclaim_hit;
	logic [EW-1:0]    scan_start;
	logic [EW-1:0]    hw_e;
	logic [EW-1:0]    row_base;
	logic [EW-1:0]    next_base;
	logic [EW-1:0]    slot_e;
	logic [EW-1:0]    slot_p1;
	logic [ROW_W-1:0] cand;
	logic [ROW_W-1:0] first_oh;
	logic [ROW_LG-1:0] hit_idx;
	logic             found;
	logic             full;
	logic             hit_bit;

	logic             ram_we;
	logic [RAW-1:0]   ram_waddr;
	logic [ROW_W-1:0] ram_wdata;
	logic [RAW-1:0]   ram_raddr;
	logic [ROW_W-1:0] ram_rdata;

	sia_ram #(
		.WIDTH (ROW_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		id_e        = CMPW'(entity_id);
		id_m1       = id_e - CMPW'(1);
		idq_m1      = CMPW'(id_q) - CMPW'(1);
		id_zero     = (entity_id == '0);
		id_in       = !id_zero && (id_e <= CMPW'(hw_q));
		reclaim_hit = (acnt_q >= reclaim_after);
		scan_start  = reclaim_hit ? '0 : EW'(cursor_q);
		hw_e        = EW'(hw_q);
		row_base    = {scan_q[EW-1:ROW_LG], ROW_LG'(0)};
		next_base   = row_base + EW'(ROW_W);
	end

	// Slots at or past the count read as free; the stored bits there are stale.
	always_comb begin
		logic [EW-1:0] p;
		for (int j = 0; j < ROW_W; j++) begin
			p = row_base + EW'(j);
			cand[j] = (ROW_LG'(j) >= scan_q[ROW_LG-1:0]) && (p < CAP_E)
				&& ((p >= hw_e) || !ram_rdata[j]);
		end
		first_oh = cand & (~cand + ROW_W'(1));
		hit_idx  = '0;
		for (int j = 0; j < ROW_W; j++) begin
			if (first_oh[j]) begin
				hit_idx = hit_idx | ROW_LG'(j);
			end
		end
		found   = |cand;
		slot_e  = row_base + EW'(hit_idx);
		slot_p1 = slot_e + EW'(1);
		full    = (next_base > hw_e) || (next_base >= CAP_E);
		hit_bit = ram_rdata[idq_m1[ROW_LG-1:0]];

		sts.quick = (func == FUNC_CLEAR) || ((func != FUNC_ADD) && !id_in);
		sts.more  = (func_q == FUNC_ADD) && !found && !full;
	end

	always_comb begin
		if (cmd.accept) begin
			ram_raddr = (func == FUNC_ADD) ? RAW'(scan_start >> ROW_LG) : RAW'(id_m1 >> ROW_LG);
		end else begin
			ram_raddr = RAW'(next_base >> ROW_LG);
		end

		if (func_q == FUNC_ADD) begin
			ram_we    = cmd.check && found;
			ram_waddr = RAW'(scan_q >> ROW_LG);
			ram_wdata = ram_rdata | first_oh;
		end else begin
			ram_we    = cmd.check && (func_q == FUNC_REMOVE) && hit_bit;
			ram_waddr = RAW'(idq_m1 >> ROW_LG);
			ram_wdata = ram_rdata & ~(ROW_W'(1) << idq_m1[ROW_LG-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			hw_q     <= '0;
			acnt_q   <= '0;
		end else if (cmd.accept) begin
			if (func == FUNC_ADD && reclaim_hit) begin
				cursor_q <= '0;
				acnt_q   <= '0;
			end
			if (func == FUNC_CLEAR) begin
				cursor_q <= '0;
				hw_q     <= '0;
			end
		end else if (cmd.check && func_q == FUNC_ADD && found) begin
			cursor_q <= CW'(slot_p1);
			acnt_q   <= acnt_q + CNT_W'(1);
			if (slot_e == hw_e) begin
				hw_q <= hw_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q   <= func_t'(func);
			id_q     <= entity_id;
			scan_q   <= scan_start;
			new_id_q <= '0;
			ok_q     <= 1'b0;
			if (func != FUNC_ADD && func != FUNC_CLEAR && id_zero) begin
				status_q <= ST_ID_ZERO;
			end else begin
				status_q <= ST_OK;
			end
		end else if (cmd.check) begin
			if (func_q == FUNC_ADD) begin
				if (found) begin
					new_id_q <= ID_W'(slot_p1);
				end else if (full) begin
					status_q <= ST_FULL;
				end else begin
					scan_q <= next_base;
				end
			end else begin
				ok_q <= hit_bit;
			end
		end
	end

	assign new_id     = new_id_q;
	assign ok         = ok_q;
	assign status     = status_q;
	assign slot_count = ID_W'(hw_q);
	assign slot_valid = (id_q != '0) && (CMPW'(id_q) <= CMPW'(hw_q));

endmodule
`default_nettype wire
